/* src/fqd_pkg.sv */
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types, sizes and helpers for the tag queue with delete.
// ----------------------------------------------------------------------------
package fqd_pkg;

  // queue capacity (2 .. 31; entry_count is 5 bits wide)
  localparam int DEPTH = 16;

  localparam int VAL_W = 32;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ECNT_W = 5;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_DELETE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DEQ,
    ST_CMP,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // circular pointer increment, wraps at DEPTH
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

/* src/fqd_ram.sv */
// ----------------------------------------------------------------------------
// fqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/fifo_queue_with_delete.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded first-in first-out queue of nonzero tags with delete-by-value.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  command  | cmd_valid/cmd_stall | command, item_value
//  response | rsp_valid/rsp_stall | status, dequeued_value, entry_count
//
//  entries live in a circular RAM (head, tail, count); one read port and one
//  comparator are reused by a small sequencer, one entry per cycle
//  enqueue and errors pass through start and done before the response is
//  registered, a dequeue through start, deq and done; a delete scans from the
//  front one entry a cycle and then moves the later entries forward one a cycle
//  a new command is taken only in idle; a stalled response holds its register
//  and the sequencer waits in done until the response slot frees up
//  synchronous reset empties the queue; RAM contents need no clearing
//
module fifo_queue_with_delete (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [1:0]                    command,
  input  logic [fqd_pkg::VAL_W-1:0]     item_value,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          status,
  output logic [fqd_pkg::VAL_W-1:0]     dequeued_value,
  output logic [fqd_pkg::ECNT_W-1:0]    entry_count
);

  // sequencer state
  fqd_pkg::state_t state, state_next;

  // queue pointers and fill count
  logic [fqd_pkg::PTR_W-1:0] head, head_next;
  logic [fqd_pkg::PTR_W-1:0] tail, tail_next;
  logic [fqd_pkg::CNT_W-1:0] count, count_next;

  // scan / compaction walk
  logic [fqd_pkg::PTR_W-1:0] scan_ptr, scan_ptr_next;
  logic [fqd_pkg::PTR_W-1:0] dst_ptr, dst_ptr_next;
  logic [fqd_pkg::CNT_W-1:0] idx, idx_next;

  // latched command and working result
  fqd_pkg::cmd_t             op, op_next;
  logic [fqd_pkg::VAL_W-1:0] val, val_next;
  logic                      res_err, res_err_next;
  logic [fqd_pkg::VAL_W-1:0] res_value, res_value_next;

  // response register
  logic                       rsp_valid_next;
  logic                       status_next;
  logic [fqd_pkg::VAL_W-1:0]  dequeued_value_next;
  logic [fqd_pkg::ECNT_W-1:0] entry_count_next;

  // ram port
  logic                      ram_wr_en;
  logic [fqd_pkg::PTR_W-1:0] ram_wr_addr;
  logic [fqd_pkg::VAL_W-1:0] ram_wr_data;
  logic                      ram_rd_en;
  logic [fqd_pkg::PTR_W-1:0] ram_rd_addr;
  logic [fqd_pkg::VAL_W-1:0] ram_rd_data;

  logic                      hit;       // shared comparator
  logic                      last;      // walk is at the back entry
  logic                      rsp_free;  // response slot can take a new result
  logic                      enq_ok;
  logic                      del_ok;

  fqd_ram #(
    .WIDTH (fqd_pkg::VAL_W),
    .DEPTH (fqd_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cmd_stall = (state != fqd_pkg::ST_IDLE);
  assign hit       = (ram_rd_data == val);
  assign last      = ((idx + fqd_pkg::CNT_W'(1)) == count);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign enq_ok    = (val != '0) && (count < fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
  assign del_ok    = (val != '0) && (count != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fqd_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = fqd_pkg::ST_START;
        end
      end
      fqd_pkg::ST_START: begin
        case (op)
          fqd_pkg::CMD_DEQUEUE: begin
            state_next = (count != '0) ? fqd_pkg::ST_DEQ : fqd_pkg::ST_DONE;
          end
          fqd_pkg::CMD_DELETE: begin
            state_next = del_ok ? fqd_pkg::ST_CMP : fqd_pkg::ST_DONE;
          end
          default: begin
            state_next = fqd_pkg::ST_DONE;
          end
        endcase
      end
      fqd_pkg::ST_DEQ: begin
        state_next = fqd_pkg::ST_DONE;
      end
      fqd_pkg::ST_CMP: begin
        if (last) begin
          state_next = fqd_pkg::ST_DONE;
        end else if (hit) begin
          state_next = fqd_pkg::ST_SHIFT;
        end
      end
      fqd_pkg::ST_SHIFT: begin
        if (last) begin
          state_next = fqd_pkg::ST_DONE;
        end
      end
      fqd_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = fqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fqd_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_next           = head;
    tail_next           = tail;
    count_next          = count;
    scan_ptr_next       = scan_ptr;
    dst_ptr_next        = dst_ptr;
    idx_next            = idx;
    op_next             = op;
    val_next            = val;
    res_err_next        = res_err;
    res_value_next      = res_value;
    status_next         = status;
    dequeued_value_next = dequeued_value;
    entry_count_next    = entry_count;
    rsp_valid_next      = rsp_valid && rsp_stall;
    ram_wr_en           = 1'b0;
    ram_wr_addr         = tail;
    ram_wr_data         = val;
    ram_rd_en           = 1'b0;
    ram_rd_addr         = head;

    case (state)
      fqd_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          op_next        = fqd_pkg::cmd_t'(command);
          val_next       = item_value;
          res_err_next   = 1'b1;
          res_value_next = '0;
        end
      end
      fqd_pkg::ST_START: begin
        case (op)
          fqd_pkg::CMD_ENQUEUE: begin
            if (enq_ok) begin
              ram_wr_en    = 1'b1;
              tail_next    = fqd_pkg::ptr_inc(tail);
              count_next   = count + fqd_pkg::CNT_W'(1);
              res_err_next = 1'b0;
            end
          end
          fqd_pkg::CMD_DEQUEUE: begin
            ram_rd_en = (count != '0);
          end
          fqd_pkg::CMD_DELETE: begin
            // start the scan at the front
            ram_rd_en     = del_ok;
            scan_ptr_next = head;
            idx_next      = '0;
          end
          default: begin
            res_err_next = 1'b1;
          end
        endcase
      end
      fqd_pkg::ST_DEQ: begin
        res_value_next = ram_rd_data;
        res_err_next   = 1'b0;
        head_next      = fqd_pkg::ptr_inc(head);
        count_next     = count - fqd_pkg::CNT_W'(1);
      end
      fqd_pkg::ST_CMP: begin
        if (hit) begin
          res_err_next = 1'b0;
        end
        if (hit && last) begin
          // deleting the back entry: just pull the tail in
          tail_next  = scan_ptr;
          count_next = count - fqd_pkg::CNT_W'(1);
        end else if (!last) begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = fqd_pkg::ptr_inc(scan_ptr);
          dst_ptr_next  = scan_ptr;
          scan_ptr_next = fqd_pkg::ptr_inc(scan_ptr);
          idx_next      = idx + fqd_pkg::CNT_W'(1);
        end
      end
      fqd_pkg::ST_SHIFT: begin
        // move the entry just read one place toward the front
        ram_wr_en   = 1'b1;
        ram_wr_addr = dst_ptr;
        ram_wr_data = ram_rd_data;
        if (last) begin
          tail_next  = scan_ptr;
          count_next = count - fqd_pkg::CNT_W'(1);
        end else begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = fqd_pkg::ptr_inc(scan_ptr);
          dst_ptr_next  = scan_ptr;
          scan_ptr_next = fqd_pkg::ptr_inc(scan_ptr);
          idx_next      = idx + fqd_pkg::CNT_W'(1);
        end
      end
      fqd_pkg::ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_next      = 1'b1;
          status_next         = res_err;
          dequeued_value_next = res_value;
          entry_count_next    = fqd_pkg::ECNT_W'(count);
        end
      end
      default: begin
        rsp_valid_next = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fqd_pkg::ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_ptr       <= scan_ptr_next;
    dst_ptr        <= dst_ptr_next;
    idx            <= idx_next;
    op             <= op_next;
    val            <= val_next;
    res_err        <= res_err_next;
    res_value      <= res_value_next;
    status         <= status_next;
    dequeued_value <= dequeued_value_next;
    entry_count    <= entry_count_next;
  end

endmodule

/* test/fqd_queue_checker.sv */
// ----------------------------------------------------------------------------
// fqd_queue_checker
// Watches both channels of the tag queue, keeps its own copy of the queue,
// predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module fqd_queue_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  logic                       cmd_stall,
  input  logic [1:0]                 command,
  input  logic [fqd_pkg::VAL_W-1:0]  item_value,
  input  logic                       rsp_valid,
  input  logic                       rsp_stall,
  input  logic                       status,
  input  logic [fqd_pkg::VAL_W-1:0]  dequeued_value,
  input  logic [fqd_pkg::ECNT_W-1:0] entry_count,
  output int                         in_flight,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       status;
    logic [fqd_pkg::VAL_W-1:0]  dequeued_value;
    logic [fqd_pkg::ECNT_W-1:0] entry_count;
  } queue_rsp_t;

  logic [fqd_pkg::VAL_W-1:0] held_tags[$];
  queue_rsp_t                awaited_rsp[$];

  // apply one command to the local queue and return the response it gives
  function automatic queue_rsp_t apply_command(input logic [1:0] cmd,
                                               input logic [fqd_pkg::VAL_W-1:0] val);
    queue_rsp_t r;
    r.status = 1'b1;
    r.dequeued_value = '0;
    case (cmd)
      fqd_pkg::CMD_ENQUEUE: begin
        if (val != '0 && held_tags.size() < fqd_pkg::DEPTH) begin
          held_tags.push_back(val);
          r.status = 1'b0;
        end
      end
      fqd_pkg::CMD_DEQUEUE: begin
        if (held_tags.size() > 0) begin
          r.dequeued_value = held_tags.pop_front();
          r.status = 1'b0;
        end
      end
      fqd_pkg::CMD_DELETE: begin
        // first match from the front; later entries close up in order
        if (val != '0) begin
          for (int i = 0; i < held_tags.size(); i++) begin
            if (held_tags[i] == val) begin
              held_tags.delete(i);
              r.status = 1'b0;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_count = fqd_pkg::ECNT_W'(held_tags.size());
    return r;
  endfunction

  always @(posedge clk) begin
    queue_rsp_t want;
    if (rst) begin
      held_tags.delete();
      awaited_rsp.delete();
    end else begin
      // response first, so a response can never match its own-cycle command
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: response with no transaction waiting: status %0d value %h count %0d",
                   $time, status, dequeued_value, entry_count);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
            fail_count++;
          end
          if (dequeued_value !== want.dequeued_value) begin
            $display("%0t: dequeued_value mismatch: expected %h, actual %h",
                     $time, want.dequeued_value, dequeued_value);
            fail_count++;
          end
          if (entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.entry_count, entry_count);
            fail_count++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        awaited_rsp.push_back(apply_command(command, item_value));
      end
    end
    in_flight = awaited_rsp.size();
  end

endmodule

/* test/fifo_queue_with_delete_tb.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_tb
// Drives commands into the tag queue with random idling on both channels and
// lets the checker predict and compare every response.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // command code the block does not define; must come back as an error
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // leave a wide margin over the slowest correct run
  localparam int CYCLE_LIMIT = 400000;
  // a delete walks the queue once; leave room for a late response
  localparam int DRAIN_CYCLES = 2 * fqd_pkg::DEPTH + 20;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_DELETE, MIX_EVEN} mix_t;

  logic                       clk;
  logic                       rst;
  logic                       cmd_valid;
  logic                       cmd_stall;
  logic [1:0]                 command;
  logic [fqd_pkg::VAL_W-1:0]  item_value;
  logic                       rsp_valid;
  logic                       rsp_stall;
  logic                       status;
  logic [fqd_pkg::VAL_W-1:0]  dequeued_value;
  logic [fqd_pkg::ECNT_W-1:0] entry_count;

  int in_flight;
  int fail_count;
  int cycle_count;

  // idle enables for the two sides, switched per phase of the run
  bit cmd_idle_en;
  bit rsp_idle_en;

  fifo_queue_with_delete dut (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .command        (command),
    .item_value     (item_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .dequeued_value (dequeued_value),
    .entry_count    (entry_count)
  );

  fqd_queue_checker queue_check (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .command        (command),
    .item_value     (item_value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .dequeued_value (dequeued_value),
    .entry_count    (entry_count),
    .in_flight      (in_flight),
    .fail_count     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // response side backpressure: random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rsp_idle_en) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 10) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // one command transaction; called and returns at a falling edge
  task automatic send_command(input logic [1:0] cmd,
                              input logic [fqd_pkg::VAL_W-1:0] val);
    int gap;
    if (cmd_idle_en && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 17);
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command <= cmd;
    item_value <= val;
    // payload holds until the edge that takes it
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  // hold off the sender until every response is back
  task automatic wait_for_responses();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
  endtask

  initial begin
    logic [1:0]                cmd;
    logic [fqd_pkg::VAL_W-1:0] val;
    logic [fqd_pkg::VAL_W-1:0] fill_val;
    int                        roll;
    mix_t                      mix;
    bit                        last_phase;

    rst = 1'b1;
    cmd_valid = 1'b0;
    command = fqd_pkg::CMD_ENQUEUE;
    item_value = '0;
    cmd_idle_en = 1'b0;
    rsp_idle_en = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: error paths on an empty queue
    send_command(fqd_pkg::CMD_DEQUEUE, 32'hDEAD_BEEF);   // empty, value ignored
    send_command(fqd_pkg::CMD_DELETE, 32'd5);            // empty never matches
    send_command(fqd_pkg::CMD_ENQUEUE, '0);              // null tag
    send_command(fqd_pkg::CMD_DELETE, '0);               // null tag
    send_command(CMD_UNUSED, 32'd7);                     // undefined command code

    // fill to capacity with extremes and repeated tags
    for (int i = 0; i < fqd_pkg::DEPTH; i++) begin
      if (i == 0) fill_val = 32'hFFFF_FFFF;
      else if (i == 1) fill_val = 32'h0000_0001;
      else if (i == 2) fill_val = 32'h8000_0000;
      else if (i == fqd_pkg::DEPTH - 1) fill_val = 32'h1234_5678;
      else fill_val = fqd_pkg::VAL_W'((i % 3) + 2);
      send_command(fqd_pkg::CMD_ENQUEUE, fill_val);
    end
    send_command(fqd_pkg::CMD_ENQUEUE, 32'd9);           // full
    send_command(fqd_pkg::CMD_DELETE, 32'h1234_5678);    // removes the back entry
    send_command(fqd_pkg::CMD_ENQUEUE, 32'h0BAD_F00D);   // must land after the rest
    send_command(fqd_pkg::CMD_DELETE, 32'd3);            // first of several matches
    send_command(fqd_pkg::CMD_DEQUEUE, 32'h5A5A_5A5A);   // value field ignored
    send_command(fqd_pkg::CMD_DELETE, 32'h0000_7777);    // no match

    wait_for_responses();

    // random phases, each with its own command mix and idling
    for (int ph = 0; ph < 10; ph++) begin
      mix = mix_t'($urandom_range(0, 3));
      last_phase = (ph == 9);
      cmd_idle_en = !last_phase && ($urandom_range(0, 3) != 0);
      rsp_idle_en = !last_phase && ($urandom_range(0, 3) != 0);
      if (ph == 5) begin
        wait_for_responses();
      end
      repeat (50) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          cmd = CMD_UNUSED;
        end else begin
          case (mix)
            MIX_FILL: begin
              cmd = (roll < 70) ? fqd_pkg::CMD_ENQUEUE :
                    (roll < 85) ? fqd_pkg::CMD_DEQUEUE : fqd_pkg::CMD_DELETE;
            end
            MIX_DRAIN: begin
              cmd = (roll < 30) ? fqd_pkg::CMD_ENQUEUE :
                    (roll < 75) ? fqd_pkg::CMD_DEQUEUE : fqd_pkg::CMD_DELETE;
            end
            MIX_DELETE: begin
              cmd = (roll < 45) ? fqd_pkg::CMD_ENQUEUE :
                    (roll < 55) ? fqd_pkg::CMD_DEQUEUE : fqd_pkg::CMD_DELETE;
            end
            default: begin
              cmd = (roll < 40) ? fqd_pkg::CMD_ENQUEUE :
                    (roll < 70) ? fqd_pkg::CMD_DEQUEUE : fqd_pkg::CMD_DELETE;
            end
          endcase
        end
        // mostly a small tag pool so deletes find matches and duplicates
        roll = $urandom_range(0, 99);
        if (roll < 60) val = fqd_pkg::VAL_W'($urandom_range(1, 12));
        else if (roll < 68) val = '0;
        else if (roll < 76) val = 32'hFFFF_FFFF;
        else val = $urandom();
        send_command(cmd, val);
      end
    end

    wait_for_responses();
    // let any late or stray response show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/fqd_pkg.sv
src/fqd_ram.sv
src/fifo_queue_with_delete.sv
test/fqd_queue_checker.sv
test/fifo_queue_with_delete_tb.sv
